// ----- rtl/core/ipdr_pkg.sv -----
package ipdr_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned SPACING_W = 16;
  localparam int unsigned CODE_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Request kinds carried in req_type
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACING  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 2'd2;

  localparam logic [SPACING_W-1:0] ZERO_SPACING_RST = 16'd1200;
  localparam logic [SPACING_W-1:0] ONE_SPACING_RST  = 16'd2200;
  localparam logic [SPACING_W-1:0] TOLERANCE_RST    = 16'd200;

  typedef struct packed {
    logic [SPACING_W-1:0] zero_spacing_us;
    logic [SPACING_W-1:0] one_spacing_us;
    logic [SPACING_W-1:0] tolerance_us;
  } ipdr_cfg_t;

  typedef struct packed {
    logic              req_type;
    logic [TIME_W-1:0] edge_time_us;
  } ipdr_item_t;

  typedef struct packed {
    logic              code_ready;
    logic [CODE_W-1:0] code_word;
    logic              read_ok;
  } ipdr_result_t;

  // True when |interval - target| < tol, all unsigned
  function automatic logic near_to(logic [TIME_W-1:0] interval,
                                   logic [SPACING_W-1:0] target,
                                   logic [SPACING_W-1:0] tol);
    logic [TIME_W-1:0] tgt;
    logic [TIME_W-1:0] diff;
    tgt  = {{(TIME_W-SPACING_W){1'b0}}, target};
    diff = (interval >= tgt) ? (interval - tgt) : (tgt - interval);
    return diff < {{(TIME_W-SPACING_W){1'b0}}, tol};
  endfunction

endpackage

// ----- rtl/core/ipdr_if.sv -----
interface ipdr_in_if import ipdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [TIME_W-1:0] edge_time_us;

  modport source (output valid, output req_type, output edge_time_us, input ready);
  modport sink   (input valid, input req_type, input edge_time_us, output ready);
endinterface

interface ipdr_out_if import ipdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              code_ready;
  logic [CODE_W-1:0] code_word;
  logic              read_ok;

  modport source (output valid, output code_ready, output code_word, output read_ok,
                  input ready);
  modport sink   (input valid, input code_ready, input code_word, input read_ok,
                  output ready);
endinterface

interface ipdr_cfg_if import ipdr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SPACING_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/ir_pulse_distance_receiver_core.sv -----
// Pulse-distance IR remote receiver.
//
// in_ch carries requests: req_type REQ_EDGE with the microsecond timestamp of
// a falling edge, or REQ_READ to fetch a received code. Every request yields
// exactly one result on out_ch: code_ready, code_word and read_ok. A read of
// a finished code returns it and clears it; a read before that returns zeros.
// cfg_ch writes the zero spacing, one spacing and match tolerance; write it
// only while no request is in flight. cfg_ch is always ready.
//
// A request passes the input register, which loads at acceptance, and then the
// result register, fed by the interval subtract, both window compares and the
// shift register update. One request is accepted per cycle when out_ch keeps
// ready high.
//
// When out_ch stalls, the result register holds and the input register can
// still take one more request; in_ch.ready then drops until out_ch drains.
// Synchronous reset (rst_n low) empties both registers, clears the partial
// code and the previous edge, and restores the default timing.
module ir_pulse_distance_receiver_core import ipdr_pkg::*; #(
  parameter int unsigned CODE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  ipdr_in_if.sink    in_ch,
  ipdr_out_if.source out_ch,
  ipdr_cfg_if.sink   cfg_ch
);

  ipdr_cfg_t    cfg;
  ipdr_item_t   in_item;
  ipdr_item_t   item;
  logic         item_valid;
  logic         advance;
  ipdr_result_t result;

  assign cfg_ch.ready = 1'b1;

  ipdr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  assign in_item.req_type     = in_ch.req_type;
  assign in_item.edge_time_us = in_ch.edge_time_us;

  ipdr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ipdr_decoder #(
    .CODE_BITS (CODE_BITS)
  ) u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .result     (result)
  );

  assign out_ch.code_ready = result.code_ready;
  assign out_ch.code_word  = result.code_word;
  assign out_ch.read_ok    = result.read_ok;

endmodule

// ----- rtl/core/ipdr_cfg_regs.sv -----
module ipdr_cfg_regs import ipdr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [SPACING_W-1:0] wr_data,
  output ipdr_cfg_t            cfg
);

  ipdr_cfg_t cfg_r;
  ipdr_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_valid) begin
      case (wr_index)
        CFG_ZERO_SPACING: cfg_nxt.zero_spacing_us = wr_data;
        CFG_ONE_SPACING:  cfg_nxt.one_spacing_us  = wr_data;
        CFG_TOLERANCE:    cfg_nxt.tolerance_us    = wr_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_spacing_us <= ZERO_SPACING_RST;
      cfg_r.one_spacing_us  <= ONE_SPACING_RST;
      cfg_r.tolerance_us    <= TOLERANCE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/ipdr_in_stage.sv -----
module ipdr_in_stage import ipdr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ipdr_item_t in_item,
  input  logic       advance,
  output logic       item_valid,
  output ipdr_item_t item
);

  logic       vld_r;
  logic       vld_nxt;
  ipdr_item_t item_r;

  // Take a new request when empty or when the held one moves on
  assign in_ready = !vld_r || advance;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

endmodule

// ----- rtl/core/ipdr_decoder.sv -----
module ipdr_decoder import ipdr_pkg::*; #(
  parameter int unsigned CODE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  ipdr_cfg_t    cfg,
  input  logic         item_valid,
  input  ipdr_item_t   item,
  output logic         advance,
  output logic         out_valid,
  input  logic         out_ready,
  output ipdr_result_t result
);

  localparam int unsigned IDX_W = $clog2(CODE_BITS + 1);
  localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(CODE_BITS);

  logic [TIME_W-1:0] prev_edge_r, prev_edge_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [IDX_W-1:0]  bit_idx_r,   bit_idx_nxt;
  logic [CODE_W-1:0] shift_r,     shift_nxt;
  logic              done_r,      done_nxt;

  logic              out_valid_r, out_valid_nxt;
  ipdr_result_t      result_r;
  ipdr_result_t      res_nxt;

  logic [TIME_W-1:0] interval;
  logic              hit_zero;
  logic              hit_one;
  logic [IDX_W-1:0]  idx_inc;
  logic              fire;

  assign advance = !out_valid_r || out_ready;
  assign fire    = advance && item_valid;

  assign interval = item.edge_time_us - prev_edge_r;
  assign hit_zero = near_to(interval, cfg.zero_spacing_us, cfg.tolerance_us);
  assign hit_one  = near_to(interval, cfg.one_spacing_us, cfg.tolerance_us);
  assign idx_inc  = bit_idx_r + IDX_W'(hit_zero || hit_one);

  always_comb begin
    prev_edge_nxt = prev_edge_r;
    have_prev_nxt = have_prev_r;
    bit_idx_nxt   = bit_idx_r;
    shift_nxt     = shift_r;
    done_nxt      = done_r;
    res_nxt       = '0;
    if (item.req_type == REQ_READ) begin
      if (done_r) begin
        res_nxt.code_ready = 1'b1;
        res_nxt.code_word  = shift_r;
        res_nxt.read_ok    = 1'b1;
        shift_nxt          = '0;
        done_nxt           = 1'b0;
      end
    end else begin
      // Edges are dropped while a finished code waits for a read
      if (!done_r) begin
        if (have_prev_r) begin
          if (!hit_zero && hit_one) begin
            shift_nxt = shift_r | (CODE_W'(1) << bit_idx_r);
          end
          if (idx_inc >= IDX_LIMIT) begin
            done_nxt      = 1'b1;
            bit_idx_nxt   = '0;
            have_prev_nxt = 1'b0;
          end else begin
            bit_idx_nxt   = idx_inc;
            prev_edge_nxt = item.edge_time_us;
          end
        end else begin
          prev_edge_nxt = item.edge_time_us;
          have_prev_nxt = 1'b1;
        end
      end
      res_nxt.code_ready = done_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_edge_r <= '0;
      have_prev_r <= 1'b0;
      bit_idx_r   <= '0;
      shift_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        prev_edge_r <= prev_edge_nxt;
        have_prev_r <= have_prev_nxt;
        bit_idx_r   <= bit_idx_nxt;
        shift_r     <= shift_nxt;
        done_r      <= done_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

// ----- rtl/core/ipdr_checker.sv -----
module ipdr_checker import ipdr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              code_ready,
  input logic [CODE_W-1:0] code_word,
  input logic              read_ok
);

  // A returned code always reports ready
  ast_read_ok_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && read_ok |-> code_ready)
    else $error("read_ok without code_ready");

  // Code word is zero unless a read returned it
  ast_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !read_ok |-> code_word == '0)
    else $error("nonzero code_word without read_ok");

  // Two successful reads never come back to back on out_ch
  ast_no_double_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && read_ok |=> !(out_valid && read_ok))
    else $error("back-to-back successful reads");

  // Stalled result holds
  ast_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(code_word) &&
      $stable(read_ok) && $stable(code_ready))
    else $error("result changed while stalled");

  ast_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ir_pulse_distance_receiver_core ipdr_checker u_ipdr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .code_ready (out_ch.code_ready),
  .code_word  (out_ch.code_word),
  .read_ok    (out_ch.read_ok)
);
